// ----- design/mbps_pkg.sv -----
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and codes of the masked byte pattern search core.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // result codes carried in the low bits of the response transaction
   typedef enum logic [1:0] {
      STATUS_FOUND     = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_OUTSIDE   = 2'd2
   } mbps_status_type;

   // configuration register indexes
   localparam logic [2:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [2:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [2:0] CSR_PATTERN_MASK = 3'd2;
   localparam logic [2:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [2:0] CSR_REGION_LOW   = 3'd4;
   localparam logic [2:0] CSR_REGION_HIGH  = 3'd5;
   localparam logic [2:0] CSR_RANGE        = 3'd6;
   localparam logic [2:0] CSR_ADJUST       = 3'd7;

   // address checks handed from the bounds unit to the scan control
   typedef struct packed {
      logic start_ok;   // start and start+range both inside the region
      logic pos_ok;     // current window may be judged
      logic edge_end;   // no further window toward the region edge
      logic limit_hit;  // current window sits on the range limit
      logic result_ok;  // adjusted match address inside the region
   } mbps_bounds_type;

endpackage

// ----- design/mbps_window.sv -----
// ----------------------------------------------------------------------------
// mbps_window
// Byte window shift register with the parallel masked pattern compare.
// ----------------------------------------------------------------------------
module mbps_window
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int LEN_BITS    = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift_en,
   input  logic                         forward,
   input  logic [LEN_BITS-1:0]          length,
   input  logic [7:0]                   data_byte,
   input  logic [PATTERN_MAX-1:0][7:0]  pattern,
   input  logic [PATTERN_MAX-1:0]       mask,
   output logic                         match
);

   logic [PATTERN_MAX-1:0][7:0] win_ff;
   logic [PATTERN_MAX-1:0][7:0] win_in;
   logic [8*(PATTERN_MAX+1)-1:0] above_ext;
   logic [8*(PATTERN_MAX+1)-1:0] below_ext;
   logic [LEN_BITS-1:0]          top_index;

   // neighbor views: above_ext byte i is entry i (zero byte on top), below_ext byte i is entry i-1
   assign above_ext = {8'h00, win_ff};
   assign below_ext = {win_ff, 8'h00};
   assign top_index = length - 1'b1;

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_in[i] = win_ff[i];
         if (forward) begin
            if (LEN_BITS'(i) == top_index) begin
               win_in[i] = data_byte;
            end else if (LEN_BITS'(i) < top_index) begin
               win_in[i] = above_ext[8*(i+1) +: 8];
            end
         end else begin
            if (i == 0) begin
               win_in[i] = data_byte;
            end else if (LEN_BITS'(i) < length) begin
               win_in[i] = below_ext[8*i +: 8];
            end
         end
      end
   end

   // compare against the window as it stands after this byte
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LEN_BITS'(i) < length && mask[i] && pattern[i] != win_in[i]) begin
            match = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

endmodule

// ----- design/mbps_bounds.sv -----
// ----------------------------------------------------------------------------
// mbps_bounds
// Region, range limit and result address checks for one scan step.
// ----------------------------------------------------------------------------
module mbps_bounds
   import mbps_pkg::*;
#(
   parameter int ADDRESS_BITS = 32,
   parameter int LEN_BITS     = 5
) (
   input  logic [ADDRESS_BITS-1:0] scan_start,
   input  logic [ADDRESS_BITS-1:0] position,
   input  logic [LEN_BITS-1:0]     length,
   input  logic [ADDRESS_BITS-1:0] region_low,
   input  logic [ADDRESS_BITS-1:0] region_high,
   input  logic [ADDRESS_BITS-1:0] range_offset,
   input  logic                    range_nonzero,
   input  logic                    forward,
   input  logic [ADDRESS_BITS-1:0] adjust,
   output mbps_bounds_type         checks,
   output logic [ADDRESS_BITS-1:0] result_address
);

   localparam int SUM_BITS = ADDRESS_BITS + 1;

   logic [ADDRESS_BITS-1:0] limit;
   logic [SUM_BITS-1:0]     window_top;
   logic [SUM_BITS-1:0]     region_top;
   logic                    beyond_limit;

   assign limit          = scan_start + range_offset;
   // top address of the window, one bit wider so it never wraps
   assign window_top     = {1'b0, position} + SUM_BITS'(length) - 1'b1;
   assign region_top     = {1'b0, region_high};
   assign result_address = position + adjust;
   assign beyond_limit   = range_nonzero && (forward ? (position > limit) : (position < limit));

   always_comb begin
      checks.start_ok  = scan_start >= region_low && scan_start <= region_high &&
                         limit >= region_low && limit <= region_high;
      checks.pos_ok    = position >= region_low && window_top <= region_top && !beyond_limit;
      checks.edge_end  = forward ? (window_top >= region_top) : (position <= region_low);
      checks.limit_hit = range_nonzero && position == limit;
      checks.result_ok = result_address >= region_low && result_address <= region_high;
   end

endmodule

// ----- design/masked_byte_pattern_search_core.sv -----
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Streams memory bytes through a window and reports the first window that
// matches a masked byte pattern inside a configured region.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  data byte, address, first (tuser), last (tlast)
//  rsp      out        rsp_tvalid/rsp_tready  scan status, result address
//  csr      in         csr_valid/csr_ready    register index, write data
//
//  one byte per cycle sustained while the receiver takes results; a result passes
//  through the input register, then the result register, after its byte is accepted
//  reset clears the configuration, the valid flags and the scan state, pattern length reads 1
//  a result held by the receiver stalls the byte in the input register,
//  which then holds req_tready low until rsp_tready returns
//  csr writes are registered, csr_ready is always high
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core
   import mbps_pkg::*;
#(
   parameter int PATTERN_MAX  = 16,
   parameter int ADDRESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], byte_address[39:8]
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // scan_status[1:0], result_address[33:2], zero[39:34]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

   // configuration
   logic [PATTERN_MAX-1:0][7:0] pattern_ff;
   logic [PATTERN_MAX-1:0]      mask_ff;
   logic [4:0]                  length_ff;
   logic [ADDRESS_BITS-1:0]     region_low_ff;
   logic [ADDRESS_BITS-1:0]     region_high_ff;
   logic [31:0]                 range_ff;
   logic [ADDRESS_BITS-1:0]     adjust_ff;

   // input register
   logic                    in_vld_ff;
   logic [7:0]              in_data_ff;
   logic [ADDRESS_BITS-1:0] in_addr_ff;
   logic                    in_first_ff;
   logic                    in_last_ff;

   // scan state
   logic [ADDRESS_BITS-1:0] start_ff;
   logic [ADDRESS_BITS-1:0] pos_ff;
   logic [LEN_BITS-1:0]     seen_ff;
   logic                    active_ff;

   // result register
   logic                    out_vld_ff;
   mbps_status_type         out_status_ff;
   logic [ADDRESS_BITS-1:0] out_addr_ff;

   logic                    fire;
   logic                    csr_write;
   logic [LEN_BITS-1:0]     length;
   logic [ADDRESS_BITS-1:0] start_addr;
   logic [ADDRESS_BITS-1:0] start_eff;
   logic [ADDRESS_BITS-1:0] pos_eff;
   logic [ADDRESS_BITS-1:0] pos_in;
   logic [LEN_BITS-1:0]     seen_base;
   logic [LEN_BITS-1:0]     seen_in;
   logic                    forward;
   logic                    active_eff;
   logic                    go;
   logic                    judge;
   logic                    match;
   logic                    emit;
   logic                    step;
   mbps_status_type         status;
   logic [ADDRESS_BITS-1:0] res_addr;
   logic [ADDRESS_BITS-1:0] match_addr;
   mbps_bounds_type         bnd;

   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'b0, 32'(out_addr_ff), out_status_ff};

   // length 0 acts as 1, above the window depth acts as the depth
   always_comb begin
      if (length_ff == 5'd0) begin
         length = LEN_BITS'(1);
      end else if (length_ff > 5'(PATTERN_MAX)) begin
         length = LEN_BITS'(PATTERN_MAX);
      end else begin
         length = LEN_BITS'(length_ff);
      end
   end

   assign forward    = !range_ff[31];
   assign start_addr = (in_addr_ff == '0) ? region_low_ff : in_addr_ff;
   assign start_eff  = in_first_ff ? start_addr : start_ff;
   assign pos_eff    = in_first_ff ? start_addr : pos_ff;
   assign active_eff = in_first_ff || active_ff;
   assign seen_base  = in_first_ff ? '0 : seen_ff;
   assign seen_in    = (seen_base < length) ? seen_base + 1'b1 : length;
   assign go         = active_eff && !(in_first_ff && (!bnd.start_ok || !bnd.pos_ok));
   assign judge      = go && seen_in == length;
   assign pos_in     = step ? (forward ? pos_eff + 1'b1 : pos_eff - 1'b1) : pos_eff;

   mbps_bounds #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .LEN_BITS     (LEN_BITS)
   ) u_bounds (
      .scan_start     (start_eff),
      .position       (pos_eff),
      .length         (length),
      .region_low     (region_low_ff),
      .region_high    (region_high_ff),
      .range_offset   (range_ff[ADDRESS_BITS-1:0]),
      .range_nonzero  (|range_ff),
      .forward        (forward),
      .adjust         (adjust_ff),
      .checks         (bnd),
      .result_address (match_addr)
   );

   mbps_window #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_BITS    (LEN_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (fire && go),
      .forward   (forward),
      .length    (length),
      .data_byte (in_data_ff),
      .pattern   (pattern_ff),
      .mask      (mask_ff),
      .match     (match)
   );

   always_comb begin
      emit     = 1'b0;
      step     = 1'b0;
      status   = STATUS_NOT_FOUND;
      res_addr = '0;
      if (in_first_ff && !bnd.start_ok) begin
         emit   = 1'b1;
         status = STATUS_OUTSIDE;
      end else if (in_first_ff && !bnd.pos_ok) begin
         emit = 1'b1;
      end else if (go) begin
         if (judge) begin
            if (!bnd.pos_ok) begin
               emit = 1'b1;
            end else if (match) begin
               emit = 1'b1;
               if (bnd.result_ok) begin
                  status   = STATUS_FOUND;
                  res_addr = match_addr;
               end
            end else if (bnd.edge_end || bnd.limit_hit) begin
               emit = 1'b1;
            end else begin
               step = 1'b1;
            end
         end
         if (!emit && in_last_ff) begin
            emit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         mask_ff        <= '0;
         length_ff      <= 5'd1;
         region_low_ff  <= '0;
         region_high_ff <= '0;
         range_ff       <= '0;
         adjust_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LOW: begin
               for (int i = 0; i < PATTERN_MAX; i++) begin
                  if (i < 8) pattern_ff[i] <= csr_data[8*(i%8) +: 8];
               end
            end
            CSR_PATTERN_HIGH: begin
               for (int i = 0; i < PATTERN_MAX; i++) begin
                  if (i >= 8) pattern_ff[i] <= csr_data[8*(i%8) +: 8];
               end
            end
            CSR_PATTERN_MASK: mask_ff        <= csr_data[PATTERN_MAX-1:0];
            CSR_PATTERN_LEN:  length_ff      <= csr_data[4:0];
            CSR_REGION_LOW:   region_low_ff  <= csr_data[ADDRESS_BITS-1:0];
            CSR_REGION_HIGH:  region_high_ff <= csr_data[ADDRESS_BITS-1:0];
            CSR_RANGE:        range_ff       <= csr_data[31:0];
            CSR_ADJUST:       adjust_ff      <= csr_data[ADDRESS_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_data_ff  <= req_tdata[7:0];
         in_addr_ff  <= req_tdata[8 +: ADDRESS_BITS];
         in_first_ff <= req_tuser;
         in_last_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         pos_ff    <= '0;
         seen_ff   <= '0;
         active_ff <= 1'b0;
      end else if (fire) begin
         start_ff  <= start_eff;
         pos_ff    <= pos_in;
         seen_ff   <= go ? seen_in : seen_base;
         active_ff <= emit ? 1'b0 : active_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (fire && emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
      if (fire && emit) begin
         out_status_ff <= status;
         out_addr_ff   <= res_addr;
      end
   end

   // a reported result always closes the scan
   assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> !active_ff)
      else $error("scan still open after a result");

   // only a found result carries an address
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_status_ff != STATUS_FOUND |-> out_addr_ff == '0)
      else $error("address on a result that is not found");

   // the fill count never runs past the window depth
   assert property (@(posedge clock) disable iff (reset)
      seen_ff <= LEN_BITS'(PATTERN_MAX))
      else $error("window fill count out of range");

   // a byte held in the input register is not dropped while stalled
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(in_data_ff))
      else $error("input transaction lost during a stall");

endmodule
